@@ rtl/core/uart_equalizer_command_decoder_macros.svh @@
// Assertion macros used by the equalizer command decoder port-level checker.
`ifndef UART_EQUALIZER_COMMAND_DECODER_MACROS_SVH
`define UART_EQUALIZER_COMMAND_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UECD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("uecd assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UECD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uecd assertion failed");

`endif

@@ rtl/core/uecd_pkg.sv @@
// Types and constants of the equalizer command decoder.
package uecd_pkg;

  // Build-time settings
  localparam int unsigned NumBandsDefault   = 8;
  localparam bit          AsciiDigits       = 1'b0;
  localparam logic [7:0]  DefaultVolumeCode = 8'd100;
  localparam logic [7:0]  DefaultGainCode   = 8'd50;
  localparam logic [7:0]  DefaultFilterType = 8'd0;
  localparam logic [7:0]  IsolateGain       = 8'd50;
  localparam logic [7:0]  DigitZero         = 8'd48;

  // Configuration port
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_START   = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET   = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_ECHO    = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_FTYPE   = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_VOLUME  = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_GAIN    = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_ISOLATE = 4'd7;

  // Event codes
  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_RESET   = 4'd1,
    EV_TYPE    = 4'd2,
    EV_VOLUME  = 4'd3,
    EV_GAIN    = 4'd4,
    EV_ISOLATE = 4'd5,
    EV_BADIDX  = 4'd6,
    EV_UNKNOWN = 4'd7,
    EV_ECHO    = 4'd8,
    EV_TIMEOUT = 4'd9
  } evt_e;

  typedef struct packed {
    logic [31:0] timeout_ticks;
    logic [7:0]  start_code;
    logic [7:0]  reset_code;
    logic [7:0]  echo_code;
    logic [7:0]  filter_type_code;
    logic [7:0]  volume_code;
    logic [7:0]  gain_code;
    logic [7:0]  isolate_code;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    evt_e       evt;
    logic [7:0] band_index;
    logic [7:0] new_value;
    logic [7:0] current_volume;
    logic [7:0] current_filter_type;
  } res_t;

endpackage

@@ rtl/core/uart_equalizer_command_decoder.sv @@
// Top level of the equalizer command decoder.
//
// Input channel: in_valid_i/in_stall_o carry one request, either a received
// byte (req_type_i = 0, rx_byte_i) or one timer tick (req_type_i = 1).
// Output channel: out_valid_o/out_stall_i carry exactly one result per
// request: event code, band index, written value and the current volume and
// filter type after that request.
// An accepted request sits in the input register, which feeds the parser
// logic, which loads the result register once that is free or draining.
// One request per cycle is sustained while the receiver does not stall; the
// parser state is read and updated in the same cycle.
// When the receiver stalls, the result register holds and one more request
// may wait in the input register; after that in_stall_o rises.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect on the
// next edge; the user writes while no request is in flight (not enforced).
// Reset empties the pipeline registers, returns the parser to hunting for the
// start byte and loads the default volume, filter type and band gains.
module uart_equalizer_command_decoder #(
  parameter int unsigned NUM_BANDS = uecd_pkg::NumBandsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uecd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uecd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [3:0]                    event_res_o,
  output logic [7:0]                    band_index_o,
  output logic [7:0]                    new_value_o,
  output logic [7:0]                    current_volume_o,
  output logic [7:0]                    current_filter_type_o
);

  uecd_pkg::cfg_t  cfg;
  uecd_pkg::item_t in_item, core_item;
  uecd_pkg::res_t  core_res, out_res;
  logic            core_vld, out_vld, adv, fire;

  assign in_item.req_type = req_type_i;
  assign in_item.rx_byte  = rx_byte_i;

  // Core advances when the result register is free or being drained
  assign adv  = ~out_vld | ~out_stall_i;
  assign fire = core_vld & adv;

  uecd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  uecd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .vld_o      (core_vld),
    .item_o     (core_item)
  );

  uecd_core #(
    .NUM_BANDS (NUM_BANDS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .item_i (core_item),
    .res_o  (core_res)
  );

  uecd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (core_res),
    .out_stall_i (out_stall_i),
    .vld_o       (out_vld),
    .res_o       (out_res)
  );

  assign out_valid_o           = out_vld;
  assign event_res_o           = out_res.evt;
  assign band_index_o          = out_res.band_index;
  assign new_value_o           = out_res.new_value;
  assign current_volume_o      = out_res.current_volume;
  assign current_filter_type_o = out_res.current_filter_type;

endmodule

@@ rtl/core/uecd_cfg.sv @@
// Configuration register file of the equalizer command decoder.
module uecd_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [uecd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [uecd_pkg::CfgDataW-1:0] cfg_data_i,
  output uecd_pkg::cfg_t               cfg_o
);

  uecd_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        uecd_pkg::CFG_TIMEOUT: cfg_d.timeout_ticks    = cfg_data_i[31:0];
        uecd_pkg::CFG_START:   cfg_d.start_code       = cfg_data_i[7:0];
        uecd_pkg::CFG_RESET:   cfg_d.reset_code       = cfg_data_i[7:0];
        uecd_pkg::CFG_ECHO:    cfg_d.echo_code        = cfg_data_i[7:0];
        uecd_pkg::CFG_FTYPE:   cfg_d.filter_type_code = cfg_data_i[7:0];
        uecd_pkg::CFG_VOLUME:  cfg_d.volume_code      = cfg_data_i[7:0];
        uecd_pkg::CFG_GAIN:    cfg_d.gain_code        = cfg_data_i[7:0];
        uecd_pkg::CFG_ISOLATE: cfg_d.isolate_code     = cfg_data_i[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks    <= 32'd32500;
      cfg_q.start_code       <= 8'd35;
      cfg_q.reset_code       <= 8'd82;
      cfg_q.echo_code        <= 8'd69;
      cfg_q.filter_type_code <= 8'd84;
      cfg_q.volume_code      <= 8'd86;
      cfg_q.gain_code        <= 8'd71;
      cfg_q.isolate_code     <= 8'd73;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/uecd_in_stage.sv @@
// Input register of the equalizer command decoder.
module uecd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  uecd_pkg::item_t item_i,
  input  logic            adv_i,
  output logic            vld_o,
  output uecd_pkg::item_t item_o
);

  logic            vld_q, vld_d;
  logic            accept;
  uecd_pkg::item_t item_q;

  // Hold while a request sits here and the core cannot take it
  assign in_stall_o = vld_q & ~adv_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

@@ rtl/core/uecd_core.sv @@
// Command parser and settings store of the equalizer command decoder.
module uecd_core #(
  parameter int unsigned NUM_BANDS = uecd_pkg::NumBandsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  uecd_pkg::cfg_t  cfg_i,
  input  logic            fire_i,
  input  uecd_pkg::item_t item_i,
  output uecd_pkg::res_t  res_o
);

  localparam int unsigned BandW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam logic [8:0]  BandLimit = 9'(NUM_BANDS);

  // Parse phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_VOL  = 3'd3;
  localparam logic [2:0] PH_GIDX = 3'd4;
  localparam logic [2:0] PH_GVAL = 3'd5;
  localparam logic [2:0] PH_ISO  = 3'd6;

  logic [2:0]       phase_q, phase_d, ph;
  logic [31:0]      wait_q, wait_d, wait_inc;
  logic [BandW-1:0] pend_q, pend_d;
  logic [7:0]       vol_q, vol_d;
  logic [7:0]       ftype_q, ftype_d;
  logic [7:0]       gain_q [NUM_BANDS];
  logic [7:0]       gain_d [NUM_BANDS];
  logic [7:0]       adj;
  logic             idx_bad;
  logic             tmo;
  uecd_pkg::res_t   res;

  // Unused phase code behaves as idle
  assign ph = (phase_q > PH_ISO) ? PH_IDLE : phase_q;

  // Saturating tick count and timeout compare
  assign wait_inc = (wait_q != '1) ? (wait_q + 32'd1) : wait_q;
  assign tmo      = (wait_inc >= cfg_i.timeout_ticks);

  // Digit option and band range check
  assign adj     = uecd_pkg::AsciiDigits ? (item_i.rx_byte - uecd_pkg::DigitZero)
                                         : item_i.rx_byte;
  assign idx_bad = ({1'b0, adj} >= BandLimit);

  // Next state and result of one request
  always_comb begin
    phase_d = ph;
    wait_d  = wait_q;
    pend_d  = pend_q;
    vol_d   = vol_q;
    ftype_d = ftype_q;
    for (int i = 0; i < NUM_BANDS; i++) begin
      gain_d[i] = gain_q[i];
    end
    res.evt        = uecd_pkg::EV_NONE;
    res.band_index = 8'd0;
    res.new_value  = 8'd0;

    if (ph == PH_IDLE) begin
      if (!item_i.req_type && (item_i.rx_byte == cfg_i.start_code)) begin
        phase_d = PH_CMD;
        wait_d  = 32'd0;
      end
    end else if (item_i.req_type) begin
      wait_d = wait_inc;
      if (tmo) begin
        if (ph == PH_VOL) begin
          vol_d         = uecd_pkg::DefaultVolumeCode;
          res.evt       = uecd_pkg::EV_VOLUME;
          res.new_value = uecd_pkg::DefaultVolumeCode;
        end else if (ph == PH_GVAL) begin
          res.band_index = 8'(pend_q);
          for (int i = 0; i < NUM_BANDS; i++) begin
            if (pend_q == BandW'(i)) begin
              gain_d[i] = uecd_pkg::DefaultGainCode;
            end
          end
          res.evt       = uecd_pkg::EV_GAIN;
          res.new_value = uecd_pkg::DefaultGainCode;
        end else begin
          res.evt = uecd_pkg::EV_TIMEOUT;
        end
        phase_d = PH_IDLE;
        wait_d  = 32'd0;
      end
    end else begin
      wait_d  = 32'd0;
      phase_d = PH_IDLE;
      unique case (ph)
        PH_CMD: begin
          // First matching register wins
          priority if (item_i.rx_byte == cfg_i.reset_code) begin
            vol_d   = uecd_pkg::DefaultVolumeCode;
            ftype_d = uecd_pkg::DefaultFilterType;
            for (int i = 0; i < NUM_BANDS; i++) begin
              gain_d[i] = uecd_pkg::DefaultGainCode;
            end
            res.evt = uecd_pkg::EV_RESET;
          end else if (item_i.rx_byte == cfg_i.echo_code) begin
            res.evt = uecd_pkg::EV_ECHO;
          end else if (item_i.rx_byte == cfg_i.filter_type_code) begin
            phase_d = PH_TYPE;
          end else if (item_i.rx_byte == cfg_i.volume_code) begin
            phase_d = PH_VOL;
          end else if (item_i.rx_byte == cfg_i.gain_code) begin
            phase_d = PH_GIDX;
          end else if (item_i.rx_byte == cfg_i.isolate_code) begin
            phase_d = PH_ISO;
          end else begin
            res.evt = uecd_pkg::EV_UNKNOWN;
          end
        end
        PH_TYPE: begin
          ftype_d       = adj;
          res.evt       = uecd_pkg::EV_TYPE;
          res.new_value = adj;
        end
        PH_VOL: begin
          vol_d         = item_i.rx_byte;
          res.evt       = uecd_pkg::EV_VOLUME;
          res.new_value = item_i.rx_byte;
        end
        PH_GIDX: begin
          if (idx_bad) begin
            res.evt        = uecd_pkg::EV_BADIDX;
            res.band_index = adj;
          end else begin
            pend_d  = adj[BandW-1:0];
            phase_d = PH_GVAL;
          end
        end
        PH_GVAL: begin
          res.band_index = 8'(pend_q);
          for (int i = 0; i < NUM_BANDS; i++) begin
            if (pend_q == BandW'(i)) begin
              gain_d[i] = item_i.rx_byte;
            end
          end
          res.evt       = uecd_pkg::EV_GAIN;
          res.new_value = item_i.rx_byte;
        end
        PH_ISO: begin
          res.band_index = adj;
          if (idx_bad) begin
            res.evt = uecd_pkg::EV_BADIDX;
          end else begin
            for (int i = 0; i < NUM_BANDS; i++) begin
              gain_d[i] = (adj == 8'(i)) ? uecd_pkg::IsolateGain : 8'd0;
            end
            res.evt       = uecd_pkg::EV_ISOLATE;
            res.new_value = uecd_pkg::IsolateGain;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    res.current_volume      = vol_d;
    res.current_filter_type = ftype_d;
  end

  // State updates only when a request is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wait_q  <= 32'd0;
      pend_q  <= '0;
      vol_q   <= uecd_pkg::DefaultVolumeCode;
      ftype_q <= uecd_pkg::DefaultFilterType;
      for (int i = 0; i < NUM_BANDS; i++) begin
        gain_q[i] <= uecd_pkg::DefaultGainCode;
      end
    end else if (fire_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      pend_q  <= pend_d;
      vol_q   <= vol_d;
      ftype_q <= ftype_d;
      for (int i = 0; i < NUM_BANDS; i++) begin
        gain_q[i] <= gain_d[i];
      end
    end
  end

  assign res_o = res;

endmodule

@@ rtl/core/uecd_out_stage.sv @@
// Result register of the equalizer command decoder.
module uecd_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  uecd_pkg::res_t res_i,
  input  logic           out_stall_i,
  output logic           vld_o,
  output uecd_pkg::res_t res_o
);

  logic           vld_q, vld_d;
  uecd_pkg::res_t res_q;

  // Valid drops once the receiver takes the result and no new one is loaded
  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

@@ rtl/core/uecd_checker.sv @@
// Port-level checker of the equalizer command decoder, bound to the top level.
`include "uart_equalizer_command_decoder_macros.svh"

module uecd_checker #(
  parameter int unsigned NUM_BANDS = uecd_pkg::NumBandsDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [3:0]                    event_res_o,
  input logic [7:0]                    band_index_o,
  input logic [7:0]                    new_value_o,
  input logic [7:0]                    current_volume_o,
  input logic [7:0]                    current_filter_type_o
);

  localparam logic [8:0] BandLimit = 9'(NUM_BANDS);

  // A stalled result holds its event, band and value
  `UECD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(event_res_o) && $stable(band_index_o) && $stable(new_value_o))

  // A stalled result holds the reported settings
  `UECD_ASSERT_NEXT(a_cur_hold, out_valid_o && out_stall_i, $stable(current_volume_o) && $stable(current_filter_type_o))

  // Only the listed event codes come out
  `UECD_ASSERT_NOW(a_evt_range, out_valid_o, event_res_o <= uecd_pkg::EV_TIMEOUT)

  // Band index is zero outside gain, isolate and bad index events
  `UECD_ASSERT_NOW(a_band_zero, out_valid_o && event_res_o != uecd_pkg::EV_GAIN && event_res_o != uecd_pkg::EV_ISOLATE && event_res_o != uecd_pkg::EV_BADIDX, band_index_o == 8'd0)

  // Isolate reports unity gain on a band in range
  `UECD_ASSERT_NOW(a_isolate, out_valid_o && event_res_o == uecd_pkg::EV_ISOLATE, new_value_o == uecd_pkg::IsolateGain && {1'b0, band_index_o} < BandLimit)

endmodule

bind uart_equalizer_command_decoder uecd_checker #(
  .NUM_BANDS (NUM_BANDS)
) u_uecd_checker (.*);

@@ verif/uart_equalizer_command_decoder_checker.sv @@
// Checker for the equalizer command decoder: predicts each result and compares it.
`timescale 1ns / 1ps

module uart_equalizer_command_decoder_checker #(
  parameter int unsigned   NUM_BANDS = uecd_pkg::NumBandsDefault,
  parameter uecd_pkg::cfg_t RESET_CFG = '0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [uecd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uecd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          req_type_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [3:0]                    event_res_i,
  input  logic [7:0]                    band_index_i,
  input  logic [7:0]                    new_value_i,
  input  logic [7:0]                    current_volume_i,
  input  logic [7:0]                    current_filter_type_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   outstanding_o
);
  import uecd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_COMMAND, PH_FTYPE, PH_VOLUME, PH_BAND, PH_GAIN_VAL, PH_ISOLATE
  } parse_phase_e;

  // Shadow of the decoder state and its registers
  cfg_t          regs;
  parse_phase_e  phase;
  logic [31:0]   wait_count;
  logic [7:0]    pending_band;
  logic [7:0]    volume;
  logic [7:0]    filter_type;
  logic [7:0]    gains [NUM_BANDS];

  res_t          expected_events [$];
  int unsigned   mismatches;

  assign fail_count_o = mismatches;

  function automatic logic [7:0] to_index(input logic [7:0] b);
    return AsciiDigits ? b - DigitZero : b;
  endfunction

  task automatic restore_defaults();
    volume      = DefaultVolumeCode;
    filter_type = DefaultFilterType;
    for (int i = 0; i < NUM_BANDS; i++) gains[i] = DefaultGainCode;
  endtask

  // One request through the command parser; returns the result it produces
  task automatic decode_request(input logic tick, input logic [7:0] b, output res_t r);
    evt_e       ev;
    logic [7:0] band;
    logic [7:0] val;
    logic [7:0] idx;
    ev   = EV_NONE;
    band = '0;
    val  = '0;
    if (phase == PH_HUNT) begin
      if (!tick && b == regs.start_code) begin
        phase      = PH_COMMAND;
        wait_count = '0;
      end
    end else if (tick) begin
      if (wait_count != '1) wait_count++;
      if (wait_count >= regs.timeout_ticks) begin
        case (phase)
          PH_VOLUME: begin
            volume = DefaultVolumeCode;
            ev     = EV_VOLUME;
            val    = volume;
          end
          PH_GAIN_VAL: begin
            band                = pending_band;
            gains[pending_band] = DefaultGainCode;
            ev                  = EV_GAIN;
            val                 = DefaultGainCode;
          end
          default: ev = EV_TIMEOUT;
        endcase
        phase      = PH_HUNT;
        wait_count = '0;
      end
    end else begin
      wait_count = '0;
      case (phase)
        PH_COMMAND: begin
          // first matching register wins when codes repeat
          phase = PH_HUNT;
          if (b == regs.reset_code) begin
            restore_defaults();
            ev = EV_RESET;
          end else if (b == regs.echo_code) begin
            ev = EV_ECHO;
          end else if (b == regs.filter_type_code) begin
            phase = PH_FTYPE;
          end else if (b == regs.volume_code) begin
            phase = PH_VOLUME;
          end else if (b == regs.gain_code) begin
            phase = PH_BAND;
          end else if (b == regs.isolate_code) begin
            phase = PH_ISOLATE;
          end else begin
            ev = EV_UNKNOWN;
          end
        end
        PH_FTYPE: begin
          filter_type = to_index(b);
          ev          = EV_TYPE;
          val         = filter_type;
          phase       = PH_HUNT;
        end
        PH_VOLUME: begin
          volume = b;
          ev     = EV_VOLUME;
          val    = b;
          phase  = PH_HUNT;
        end
        PH_BAND: begin
          idx = to_index(b);
          if (idx >= NUM_BANDS) begin
            ev    = EV_BADIDX;
            band  = idx;
            phase = PH_HUNT;
          end else begin
            pending_band = idx;
            phase        = PH_GAIN_VAL;
          end
        end
        PH_GAIN_VAL: begin
          band                = pending_band;
          gains[pending_band] = b;
          ev                  = EV_GAIN;
          val                 = b;
          phase               = PH_HUNT;
        end
        default: begin
          // isolate: chosen band to unity, all others muted
          idx  = to_index(b);
          band = idx;
          if (idx >= NUM_BANDS) begin
            ev = EV_BADIDX;
          end else begin
            for (int i = 0; i < NUM_BANDS; i++) gains[i] = (i == idx) ? IsolateGain : '0;
            ev  = EV_ISOLATE;
            val = IsolateGain;
          end
          phase = PH_HUNT;
        end
      endcase
    end
    r.evt                 = ev;
    r.band_index          = band;
    r.new_value           = val;
    r.current_volume      = volume;
    r.current_filter_type = filter_type;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      regs         = RESET_CFG;
      phase        = PH_HUNT;
      wait_count   = '0;
      pending_band = '0;
      restore_defaults();
      expected_events.delete();
      mismatches    = 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual event %0d",
                   $time, event_res_i);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          compare_field("event_res", want.evt, event_res_i);
          compare_field("band_index", want.band_index, band_index_i);
          compare_field("new_value", want.new_value, new_value_i);
          compare_field("current_volume", want.current_volume, current_volume_i);
          compare_field("current_filter_type", want.current_filter_type,
                        current_filter_type_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_request(req_type_i, rx_byte_i, want);
        expected_events.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TIMEOUT: regs.timeout_ticks    = cfg_data_i;
          CFG_START:   regs.start_code       = cfg_data_i[7:0];
          CFG_RESET:   regs.reset_code       = cfg_data_i[7:0];
          CFG_ECHO:    regs.echo_code        = cfg_data_i[7:0];
          CFG_FTYPE:   regs.filter_type_code = cfg_data_i[7:0];
          CFG_VOLUME:  regs.volume_code      = cfg_data_i[7:0];
          CFG_GAIN:    regs.gain_code        = cfg_data_i[7:0];
          CFG_ISOLATE: regs.isolate_code     = cfg_data_i[7:0];
          default: ;
        endcase
      end
      outstanding_o <= expected_events.size();
    end
  end

endmodule

@@ verif/uart_equalizer_command_decoder_test.sv @@
// Testbench top for the equalizer command decoder: stimulus, settings and verdict.
`timescale 1ns / 1ps

module uart_equalizer_command_decoder_test;
  import uecd_pkg::*;

  localparam int unsigned NumBands  = NumBandsDefault;
  localparam int unsigned CycleCap  = 400000;
  localparam logic        REQ_BYTE  = 1'b0;
  localparam logic        REQ_TICK  = 1'b1;
  // index past the last register; writes there are dropped
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 4'd15;

  localparam cfg_t CfgAtReset = '{
    timeout_ticks: 32'd32500, start_code: 8'd35, reset_code: 8'd82, echo_code: 8'd69,
    filter_type_code: 8'd84, volume_code: 8'd86, gain_code: 8'd71, isolate_code: 8'd73
  };

  typedef enum int {
    OP_RESET, OP_ECHO, OP_FTYPE, OP_VOLUME, OP_GAIN, OP_ISOLATE, OP_UNKNOWN
  } cmd_op_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                req_type_i  = REQ_BYTE;
  logic [7:0]          rx_byte_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [3:0]          event_res_o;
  logic [7:0]          band_index_o;
  logic [7:0]          new_value_o;
  logic [7:0]          current_volume_o;
  logic [7:0]          current_filter_type_o;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned items_sent = 0;
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned cycles     = 0;
  cfg_t        cur_cfg    = CfgAtReset;

  uart_equalizer_command_decoder #(
    .NUM_BANDS(NumBands)
  ) DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .req_type_i, .rx_byte_i,
    .out_valid_o, .out_stall_i, .event_res_o, .band_index_o, .new_value_o,
    .current_volume_o, .current_filter_type_o
  );

  uart_equalizer_command_decoder_checker #(
    .NUM_BANDS(NumBands),
    .RESET_CFG(CfgAtReset)
  ) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .rx_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .event_res_i(event_res_o), .band_index_i(band_index_o), .new_value_i(new_value_o),
    .current_volume_i(current_volume_o), .current_filter_type_i(current_filter_type_o),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Watchdog
  initial begin
    while (cycles < CycleCap) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("uart_equalizer_command_decoder verification failed");
    $finish;
  end

  // One request, after a random gap; returns once accepted
  task automatic send_request(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(REQ_BYTE, b);
  endtask

  task automatic send_tick();
    send_request(REQ_TICK, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] band_code(input logic [7:0] idx);
    return AsciiDigits ? idx + DigitZero : idx;
  endfunction

  // Mostly valid bands, some out of range
  function automatic logic [7:0] pick_band();
    if ($urandom_range(99) < 15) return 8'($urandom_range(255));
    return band_code(8'($urandom_range(NumBands - 1)));
  endfunction

  // Occasional ticks inside a command; short timeouts can expire here
  task automatic idle_ticks();
    int unsigned span;
    if ($urandom_range(99) >= 25) return;
    span = (cur_cfg.timeout_ticks <= 4) ? cur_cfg.timeout_ticks + 1 : 2;
    repeat ($urandom_range(span)) send_tick();
  endtask

  // A command frame with random content
  task automatic send_frame();
    cmd_op_e    op;
    logic [7:0] cmd;
    op = cmd_op_e'($urandom_range(OP_UNKNOWN));
    case (op)
      OP_RESET:   cmd = cur_cfg.reset_code;
      OP_ECHO:    cmd = cur_cfg.echo_code;
      OP_FTYPE:   cmd = cur_cfg.filter_type_code;
      OP_VOLUME:  cmd = cur_cfg.volume_code;
      OP_GAIN:    cmd = cur_cfg.gain_code;
      OP_ISOLATE: cmd = cur_cfg.isolate_code;
      default:    cmd = 8'($urandom_range(255));
    endcase
    send_byte(cur_cfg.start_code);
    idle_ticks();
    send_byte(cmd);
    if (op == OP_GAIN) begin
      idle_ticks();
      send_byte(pick_band());
    end
    case (op)
      OP_FTYPE, OP_VOLUME, OP_GAIN: begin
        idle_ticks();
        send_byte(8'($urandom_range(255)));
      end
      OP_ISOLATE: begin
        idle_ticks();
        send_byte(pick_band());
      end
      default: ;
    endcase
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) send_frame();
      else if ($urandom_range(1) != 0) send_tick();
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  // Stop sending and wait for every expected result to come out
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all registers, plus one write to an unused index
  task automatic load_settings(input cfg_t c);
    logic [CfgDataW-1:0] data;
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_UNUSED;
    cfg_data_i  <= $urandom;
    @(posedge clk_i);
    for (int k = CFG_TIMEOUT; k <= CFG_ISOLATE; k++) begin
      case (CfgIdxW'(k))
        CFG_TIMEOUT: data = c.timeout_ticks;
        CFG_START:   data = CfgDataW'(c.start_code);
        CFG_RESET:   data = CfgDataW'(c.reset_code);
        CFG_ECHO:    data = CfgDataW'(c.echo_code);
        CFG_FTYPE:   data = CfgDataW'(c.filter_type_code);
        CFG_VOLUME:  data = CfgDataW'(c.volume_code);
        CFG_GAIN:    data = CfgDataW'(c.gain_code);
        default:     data = CfgDataW'(c.isolate_code);
      endcase
      cfg_index_i <= CfgIdxW'(k);
      cfg_data_i  <= data;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  initial begin
    cfg_t c;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command and field extremes at reset settings
    send_byte(8'h00);
    send_tick();
    send_byte(cur_cfg.start_code);
    send_byte(cur_cfg.reset_code);
    send_byte(cur_cfg.start_code);
    send_byte(cur_cfg.echo_code);
    send_byte(cur_cfg.start_code);
    send_byte(cur_cfg.filter_type_code);
    send_byte(8'hFF);
    send_byte(cur_cfg.start_code);
    send_byte(cur_cfg.volume_code);
    send_byte(8'h00);
    send_byte(cur_cfg.start_code);
    send_byte(cur_cfg.gain_code);
    send_byte(band_code(8'(NumBands - 1)));
    send_byte(8'hFF);
    send_byte(cur_cfg.start_code);
    send_byte(cur_cfg.gain_code);
    send_byte(8'hFF);
    send_byte(cur_cfg.start_code);
    send_byte(cur_cfg.isolate_code);
    send_byte(band_code(8'h00));
    send_byte(cur_cfg.start_code);
    send_byte(cur_cfg.isolate_code);
    send_byte(8'hFF);
    send_byte(cur_cfg.start_code);
    send_byte(8'hFF);

    // Timeout of one tick, extreme codes; one timeout per wait, then random
    c = '{timeout_ticks: 32'd1, start_code: 8'h00, reset_code: 8'hFF, echo_code: 8'h01,
          filter_type_code: 8'h02, volume_code: 8'h03, gain_code: 8'h04,
          isolate_code: 8'h05};
    load_settings(c);
    send_byte(c.start_code);
    send_tick();
    send_byte(c.start_code);
    send_byte(c.filter_type_code);
    send_tick();
    send_byte(c.start_code);
    send_byte(c.volume_code);
    send_tick();
    send_byte(c.start_code);
    send_byte(c.gain_code);
    send_byte(band_code(8'd3));
    send_tick();
    send_byte(c.start_code);
    send_byte(c.gain_code);
    send_tick();
    send_byte(c.start_code);
    send_byte(c.isolate_code);
    send_tick();
    run_random(140);

    // Repeated command codes, sender idling
    c = '{timeout_ticks: 32'd3, start_code: 8'hFF, reset_code: 8'h10, echo_code: 8'h10,
          filter_type_code: 8'h20, volume_code: 8'h20, gain_code: 8'h30,
          isolate_code: 8'h30};
    load_settings(c);
    gap_pct = 64;
    run_random(140);

    // Zero timeout, reset codes, receiver stalling
    c = CfgAtReset;
    c.timeout_ticks = 32'd0;
    load_settings(c);
    gap_pct   = 0;
    stall_pct = 64;
    run_random(140);

    // Longest timeout, random codes, both sides idling
    c = '{timeout_ticks: 32'hFFFF_FFFF, start_code: 8'($urandom_range(255)),
          reset_code: 8'($urandom_range(255)), echo_code: 8'($urandom_range(255)),
          filter_type_code: 8'($urandom_range(255)), volume_code: 8'($urandom_range(255)),
          gain_code: 8'($urandom_range(255)), isolate_code: 8'($urandom_range(255))};
    load_settings(c);
    gap_pct   = 21;
    stall_pct = 21;
    run_random(140);

    // Short timeout, full rate, with a full drain in the middle
    c = '{timeout_ticks: 32'd2, start_code: 8'hAA, reset_code: 8'h55, echo_code: 8'h0F,
          filter_type_code: 8'hF0, volume_code: 8'h3C, gain_code: 8'hC3,
          isolate_code: 8'h99};
    load_settings(c);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(70);
    settle();
    run_random(70);

    settle();
    if (fail_count == 0) begin
      $display("uart_equalizer_command_decoder verification clean");
    end else begin
      $display("uart_equalizer_command_decoder verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/uecd_pkg.sv
rtl/core/uecd_cfg.sv
rtl/core/uecd_in_stage.sv
rtl/core/uecd_core.sv
rtl/core/uecd_out_stage.sv
rtl/core/uart_equalizer_command_decoder.sv
rtl/core/uecd_checker.sv
verif/uart_equalizer_command_decoder_checker.sv
verif/uart_equalizer_command_decoder_test.sv
